>>> sv/dgm_pkg.sv
// Shared types, constants and helpers for the DMX grand master universe store.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package dgm_pkg;

  // Field widths of one request and one result
  localparam int CH_W        = 12;
  localparam int VAL_W       = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // Master level after reset
  localparam logic [VAL_W-1:0] MASTER_RESET = 8'hFF;

  // Configuration register indexes (selected by paddr[2])
  localparam logic REG_LIMIT_MODE = 1'b0;
  localparam logic REG_ALL_MODE   = 1'b1;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_SET_MASTER = 2'd1,
    OP_CLEAR_SET  = 2'd2,
    OP_READ       = 2'd3
  } dgm_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;     // capture the accepted request
    logic cnt_clr;   // zero the channel walk counter
    logic cnt_inc;   // advance the channel walk counter
    logic rd_ch;     // read both stores at the request channel
    logic rd_cnt;    // read both stores at the walk counter
    logic mul_val;   // multiply the request byte by the master
    logic mul_mem;   // multiply the stored raw byte by the master
    logic wr_chan;   // commit a channel write
    logic wr_walk;   // rewrite the walked channel if it is a member
    logic wr_zero;   // zero both stores at the walk counter
    logic wr_mclr;   // zero the member bit at the walk counter
    logic set_gm;    // load the new master level
    logic post;      // load the result register
  } dgm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    dgm_op_t op;
    logic    in_range;
    logic    cnt_last;
    logic    out_free;
  } dgm_sts_t;

  // Round v*gm/255 to nearest, halves up: floor((p + 127) / 255) for p = v*gm
  function automatic logic [VAL_W-1:0] div255_round(input logic [2*VAL_W-1:0] p);
    logic [2*VAL_W:0] t;
    t = {1'b0, p} + 17'd128;
    t = t + (t >> 8);
    return t[15:8];
  endfunction

endpackage

>>> sv/dgm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dgm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/dgm_datapath.sv
// Datapath: channel stores, member store, master level, scaler and result register.
// Depends on dgm_pkg and dgm_ram.
`timescale 1ns / 1ps

module dgm_datapath #(
  parameter int UNIVERSE_SIZE = 512
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dgm_pkg::dgm_cmd_t                 cmd_i,
  output dgm_pkg::dgm_sts_t                 sts_o,
  input  logic                              limit_mode_i,
  input  logic                              all_mode_i,
  input  logic [1:0]                        in_cmd_i,
  input  logic [dgm_pkg::CH_W-1:0]          in_channel_i,
  input  logic [dgm_pkg::VAL_W-1:0]         in_value_i,
  input  logic                              in_is_intensity_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_ok_o,
  output logic [dgm_pkg::VAL_W-1:0]         out_pre_value_o,
  output logic [dgm_pkg::VAL_W-1:0]         out_post_value_o
);

  localparam int AW = (UNIVERSE_SIZE > 1) ? $clog2(UNIVERSE_SIZE) : 1;
  localparam int VW = dgm_pkg::VAL_W;

  // Captured request
  dgm_pkg::dgm_op_t           op_r;
  logic [dgm_pkg::CH_W-1:0]   ch_r;
  logic [VW-1:0]              val_r;
  logic                       inten_r;

  // Master level, walk counter, scaler operands
  logic [VW-1:0]   gm_r;
  logic [AW-1:0]   cnt_r;
  logic [VW-1:0]   src_r;
  logic [2*VW-1:0] prod_r;
  logic            mem_r;

  // Result register
  logic            out_valid_r;
  logic            out_ok_r;
  logic [VW-1:0]   out_pre_r;
  logic [VW-1:0]   out_post_r;
  logic            out_valid_nxt;

  logic [AW-1:0]   ch_addr;
  logic            in_range;
  logic            affected;
  logic [VW-1:0]   apply_out;
  logic [VW-1:0]   wr_post;
  logic [VW-1:0]   src_nxt;

  logic            data_we;
  logic [AW-1:0]   data_waddr;
  logic [2*VW-1:0] data_wdata;
  logic            mbr_we;
  logic            mbr_wdata;
  logic            rd_en;
  logic [AW-1:0]   raddr;
  logic [2*VW-1:0] data_rd;
  logic            mbr_rd;

  logic            res_ok;
  logic [VW-1:0]   res_pre;
  logic [VW-1:0]   res_post;

  assign ch_addr  = ch_r[AW-1:0];
  assign in_range = ({1'b0, ch_r} < (dgm_pkg::CH_W + 1)'(UNIVERSE_SIZE));
  assign affected = all_mode_i | inten_r;

  // Master applied to the operand in src_r
  assign apply_out = limit_mode_i ? ((src_r < gm_r) ? src_r : gm_r)
                                  : dgm_pkg::div255_round(prod_r);

  // Mastered byte of a channel write
  always_comb begin
    if (val_r == '0) begin
      wr_post = '0;
    end else if (affected) begin
      wr_post = apply_out;
    end else begin
      wr_post = val_r;
    end
  end

  assign src_nxt = cmd_i.mul_mem ? data_rd[VW-1:0] : val_r;

  // Store ports: word is {mastered, raw}
  always_comb begin
    data_we    = cmd_i.wr_chan | (cmd_i.wr_walk & mem_r) | cmd_i.wr_zero;
    data_waddr = cmd_i.wr_chan ? ch_addr : cnt_r;
    if (cmd_i.wr_chan) begin
      data_wdata = {wr_post, val_r};
    end else if (cmd_i.wr_walk) begin
      data_wdata = {apply_out, src_r};
    end else begin
      data_wdata = '0;
    end
    mbr_we = (cmd_i.wr_chan & ((val_r == '0) | affected)) | (cmd_i.wr_walk & mem_r) |
             cmd_i.wr_zero | cmd_i.wr_mclr;
    if (cmd_i.wr_chan) begin
      mbr_wdata = (val_r != '0);
    end else if (cmd_i.wr_walk) begin
      mbr_wdata = (src_r != '0);
    end else begin
      mbr_wdata = 1'b0;
    end
    rd_en = cmd_i.rd_ch | cmd_i.rd_cnt;
    raddr = cmd_i.rd_ch ? ch_addr : cnt_r;
  end

  dgm_ram #(
    .WIDTH (2*VW),
    .DEPTH (UNIVERSE_SIZE),
    .ADDR_W(AW)
  ) u_level_ram (
    .clk  (clk),
    .we   (data_we),
    .waddr(data_waddr),
    .wdata(data_wdata),
    .re   (rd_en),
    .raddr(raddr),
    .rdata(data_rd)
  );

  dgm_ram #(
    .WIDTH (1),
    .DEPTH (UNIVERSE_SIZE),
    .ADDR_W(AW)
  ) u_member_ram (
    .clk  (clk),
    .we   (mbr_we),
    .waddr(data_waddr),
    .wdata(mbr_wdata),
    .re   (rd_en),
    .raddr(raddr),
    .rdata(mbr_rd)
  );

  // Result of the current request
  always_comb begin
    res_ok   = 1'b1;
    res_pre  = '0;
    res_post = '0;
    case (op_r)
      dgm_pkg::OP_WRITE: begin
        res_ok = in_range;
        if (in_range) begin
          res_pre  = val_r;
          res_post = wr_post;
        end
      end
      dgm_pkg::OP_READ: begin
        res_ok = in_range;
        if (in_range) begin
          res_pre  = data_rd[VW-1:0];
          res_post = data_rd[2*VW-1:VW];
        end
      end
      default: begin
        res_ok = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cmd_i.post) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready_i) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gm_r        <= dgm_pkg::MASTER_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd_i.set_gm) begin
        gm_r <= val_r;
      end
      if (cmd_i.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.latch) begin
      op_r    <= dgm_pkg::dgm_op_t'(in_cmd_i);
      ch_r    <= in_channel_i;
      val_r   <= in_value_i;
      inten_r <= in_is_intensity_i;
    end
    if (cmd_i.mul_val | cmd_i.mul_mem) begin
      src_r  <= src_nxt;
      prod_r <= src_nxt * gm_r;
    end
    if (cmd_i.mul_mem) begin
      mem_r <= mbr_rd;
    end
    if (cmd_i.post) begin
      out_ok_r   <= res_ok;
      out_pre_r  <= res_pre;
      out_post_r <= res_post;
    end
  end

  assign sts_o.op       = op_r;
  assign sts_o.in_range = in_range;
  assign sts_o.cnt_last = (cnt_r == AW'(UNIVERSE_SIZE - 1));
  assign sts_o.out_free = ~out_valid_r | out_ready_i;

  assign out_valid_o      = out_valid_r;
  assign out_ok_o         = out_ok_r;
  assign out_pre_value_o  = out_pre_r;
  assign out_post_value_o = out_post_r;

endmodule

>>> sv/dgm_ctrl.sv
// Controller: sequences clearing after reset, channel writes and reads,
// the master re-apply walk and the member clear sweep. Depends on dgm_pkg.
`timescale 1ns / 1ps

module dgm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dgm_pkg::dgm_sts_t sts_i,
  output dgm_pkg::dgm_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_WR,
    S_GM_RD,
    S_GM_MUL,
    S_GM_WR,
    S_MCLR,
    S_POST
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd_o.wr_zero = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.op)
          dgm_pkg::OP_WRITE: begin
            if (sts_i.in_range) begin
              cmd_o.mul_val = 1'b1;
              state_nxt     = S_WR;
            end else begin
              state_nxt = S_POST;
            end
          end
          dgm_pkg::OP_SET_MASTER: begin
            cmd_o.set_gm  = 1'b1;
            cmd_o.cnt_clr = 1'b1;
            state_nxt     = S_GM_RD;
          end
          dgm_pkg::OP_CLEAR_SET: begin
            cmd_o.cnt_clr = 1'b1;
            state_nxt     = S_MCLR;
          end
          default: begin
            cmd_o.rd_ch = sts_i.in_range;
            state_nxt   = S_POST;
          end
        endcase
      end
      S_WR: begin
        cmd_o.wr_chan = 1'b1;
        state_nxt     = S_POST;
      end
      S_GM_RD: begin
        cmd_o.rd_cnt = 1'b1;
        state_nxt    = S_GM_MUL;
      end
      S_GM_MUL: begin
        cmd_o.mul_mem = 1'b1;
        state_nxt     = S_GM_WR;
      end
      S_GM_WR: begin
        cmd_o.wr_walk = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_nxt     = sts_i.cnt_last ? S_POST : S_GM_RD;
      end
      S_MCLR: begin
        cmd_o.wr_mclr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        // Hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.post = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Only one store write source at a time
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd_o.wr_chan, cmd_o.wr_walk, cmd_o.wr_zero, cmd_o.wr_mclr}))
    else $error("dgm_ctrl: conflicting store writes");

  // Never overwrite an untaken result
  a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.post |-> sts_i.out_free)
    else $error("dgm_ctrl: result posted while output busy");

  // The master walk ends on the last channel and then reports
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GM_WR && sts_i.cnt_last) |=> (state_r == S_POST))
    else $error("dgm_ctrl: master walk did not finish");

  // No request taken while a store operation is in flight
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.wr_zero || cmd_o.wr_walk || cmd_o.wr_mclr || cmd_o.wr_chan) |-> !in_ready_o)
    else $error("dgm_ctrl: request accepted during store update");

endmodule

>>> sv/dmx_grand_master_universe.sv
// The master walk handles one channel at a time, reading, scaling and rewriting it
// through the single read and write port of each store.
// One request at a time; the next is taken the cycle after the result posts.
// Reset (synchronous, rst_n low): master 255, modes 0, then a clearing pass over all
// UNIVERSE_SIZE channels zeroes all stores before the first request is accepted.
`timescale 1ns / 1ps

module dmx_grand_master_universe #(
  parameter int UNIVERSE_SIZE = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // cmd[1:0], channel[13:2], value[21:14], is_intensity[22]
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // ok[0], pre_value[8:1], post_value[16:9]
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  dgm_pkg::dgm_cmd_t cmd;
  dgm_pkg::dgm_sts_t sts;

  logic limit_mode_r;
  logic all_mode_r;
  logic cfg_wr;

  logic                        out_ok;
  logic [dgm_pkg::VAL_W-1:0]   out_pre;
  logic [dgm_pkg::VAL_W-1:0]   out_post;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_mode_r <= 1'b0;
      all_mode_r   <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == dgm_pkg::REG_ALL_MODE) begin
        all_mode_r <= cfg_pwdata[0];
      end else begin
        limit_mode_r <= cfg_pwdata[0];
      end
    end
  end

  assign cfg_prdata = {31'd0, (cfg_paddr[2] == dgm_pkg::REG_ALL_MODE) ? all_mode_r
                                                                        : limit_mode_r};

  dgm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid_i(in_tvalid),
    .in_ready_o(in_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dgm_datapath #(
    .UNIVERSE_SIZE(UNIVERSE_SIZE)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .limit_mode_i     (limit_mode_r),
    .all_mode_i       (all_mode_r),
    .in_cmd_i         (in_tdata[1:0]),
    .in_channel_i     (in_tdata[13:2]),
    .in_value_i       (in_tdata[21:14]),
    .in_is_intensity_i(in_tdata[22]),
    .out_valid_o      (out_tvalid),
    .out_ready_i      (out_tready),
    .out_ok_o         (out_ok),
    .out_pre_value_o  (out_pre),
    .out_post_value_o (out_post)
  );

  assign out_tdata = {7'd0, out_post, out_pre, out_ok};

endmodule
